@@ hw/rtl/dlps_pkg.sv @@
`default_nettype none

package dlps_pkg;

	// store geometry: 4096 samples per channel, window of 2048 samples
	localparam int BUF_AW  = 12;
	localparam int FRAC_W  = 16;
	localparam int POS_W   = BUF_AW + FRAC_W;
	localparam int DL_LOG2 = 11;
	localparam int PH_W    = DL_LOG2 + FRAC_W;

	// unity pitch and full wet share
	localparam logic [17:0] PITCH_UNITY = 18'd65536;
	localparam logic [15:0] DW_FULL     = 16'd32768;

	// register indexes on the configuration port
	localparam logic [1:0] REG_ENABLE   = 2'd0;
	localparam logic [1:0] REG_CHANNELS = 2'd1;
	localparam logic [1:0] REG_PITCH    = 2'd2;
	localparam logic [1:0] REG_DRY_WET  = 2'd3;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WR,
		ST_RD0,
		ST_RD1,
		ST_RD2,
		ST_RD3,
		ST_C1,
		ST_C2,
		ST_C3,
		ST_C4,
		ST_C5,
		ST_C6
	} dlps_state_t;

	typedef struct packed {
		logic        enable;
		logic [1:0]  channels;
		logic [17:0] pitch;
		logic [15:0] dry_wet;
	} dlps_cfg_t;

	// sequencer to lane control
	typedef struct packed {
		logic              load;
		logic              we;
		logic              wr_zero;
		logic [BUF_AW-1:0] addr;
		logic              cap_a0;
		logic              cap_a1;
		logic              cap_b0;
		logic              do_c1;
		logic              do_c2;
		logic              do_c3;
		logic              do_c4;
		logic              do_c5;
		logic              pass;
		logic [15:0]       f1;
		logic [15:0]       f2;
		logic [16:0]       w1;
		logic [15:0]       dw;
	} dlps_ctl_t;

endpackage

`default_nettype wire

@@ hw/rtl/dlps_ram.sv @@
`default_nettype none

module dlps_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// single port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

`default_nettype wire

@@ hw/rtl/dlps_lane.sv @@
`default_nettype none

module dlps_lane
	import dlps_pkg::*;
(
	input  wire logic             clk,
	input  wire dlps_ctl_t        ctl,
	input  wire logic             active,
	input  wire logic signed [15:0] x_in,
	output logic signed [15:0]    y
);

	// divide by 2^16 truncating toward zero
	function automatic logic signed [15:0] shr16_tz(input logic signed [35:0] v);
		logic signed [35:0] b;
		b = v + (v[35] ? 36'sd65535 : 36'sd0);
		return b[31:16];
	endfunction

	// divide by 2^15 truncating toward zero, then saturate
	function automatic logic signed [15:0] shr15_sat(input logic signed [35:0] v);
		logic signed [35:0] b;
		logic signed [20:0] t;
		b = v + (v[35] ? 36'sd32767 : 36'sd0);
		t = b[35:15];
		if (t > 21'sd32767) begin
			return 16'sh7FFF;
		end else if (t < -21'sd32768) begin
			return 16'sh8000;
		end
		return t[15:0];
	endfunction

	logic        [15:0] rdata;
	logic signed [15:0] x_q;
	logic signed [15:0] a0_q, a1_q, b0_q;
	logic signed [33:0] p1_q, p2_q;
	logic signed [15:0] tap1_q, tap2_q, wet_q;
	logic signed [34:0] wprod_q;
	logic signed [33:0] mprod_q;
	logic signed [16:0] da, db, dt, dm;
	logic               ram_we;
	logic        [15:0] ram_wdata;

	// store write: sample, or zero during the clearing sweep
	assign ram_we    = ctl.we && (active || ctl.wr_zero);
	assign ram_wdata = ctl.wr_zero ? 16'h0000 : x_q;

	dlps_ram #(
		.WIDTH(16),
		.DEPTH(1 << BUF_AW)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.addr (ctl.addr),
		.wdata(ram_wdata),
		.rdata(rdata)
	);

	// tap differences and crossfade / mix deltas
	assign da = $signed({a1_q[15], a1_q}) - $signed({a0_q[15], a0_q});
	assign db = $signed({rdata[15], rdata}) - $signed({b0_q[15], b0_q});
	assign dt = $signed({tap1_q[15], tap1_q}) - $signed({tap2_q[15], tap2_q});
	assign dm = $signed({wet_q[15], wet_q}) - $signed({x_q[15], x_q});

	// sample capture and arithmetic steps
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			x_q <= x_in;
		end
		if (ctl.cap_a0) begin
			a0_q <= $signed(rdata);
		end
		if (ctl.cap_a1) begin
			a1_q <= $signed(rdata);
		end
		if (ctl.cap_b0) begin
			b0_q <= $signed(rdata);
			p1_q <= da * $signed({1'b0, ctl.f1});
		end
		if (ctl.do_c1) begin
			p2_q   <= db * $signed({1'b0, ctl.f2});
			tap1_q <= shr16_tz($signed({{4{a0_q[15]}}, a0_q, 16'h0000}) + 36'(p1_q));
		end
		if (ctl.do_c2) begin
			tap2_q <= shr16_tz($signed({{4{b0_q[15]}}, b0_q, 16'h0000}) + 36'(p2_q));
		end
		if (ctl.do_c3) begin
			wprod_q <= dt * $signed({1'b0, ctl.w1});
		end
		if (ctl.do_c4) begin
			wet_q <= shr16_tz($signed({{4{tap2_q[15]}}, tap2_q, 16'h0000}) + 36'(wprod_q));
		end
		if (ctl.do_c5) begin
			mprod_q <= dm * $signed({1'b0, ctl.dw});
		end
	end

	// final mix, or the input itself for unity pitch and an idle channel
	always_comb begin
		if (ctl.pass || !active) begin
			y = x_q;
		end else begin
			y = shr15_sat($signed({{5{x_q[15]}}, x_q, 15'h0000}) + 36'(mprod_q));
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/dlps_ctrl.sv @@
`default_nettype none

module dlps_ctrl
	import dlps_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire dlps_cfg_t cfg,
	input  wire logic      in_valid,
	input  wire logic      out_free,
	output logic           in_ready,
	output logic           done,
	output dlps_ctl_t      ctl
);

	dlps_state_t state_q, state_d;

	logic [BUF_AW-1:0] clr_q;
	logic [BUF_AW-1:0] wp_q;
	logic [PH_W-1:0]   phase_q;
	logic              pass_q;
	logic [POS_W-1:0]  pos1_q, pos2_q;
	logic [16:0]       w1_q;
	logic [15:0]       dw_q;

	logic [PH_W-1:0]   d2;
	logic [POS_W-1:0]  pos1, pos2;
	logic signed [PH_W+1:0] dist_s;
	logic [PH_W:0]     dist_mag;
	logic [16:0]       w1;
	logic signed [PH_W+1:0] ph_sum;
	logic [PH_W-1:0]   ph_next;
	logic              start;

	assign start = (state_q == ST_IDLE) && in_valid && out_free && cfg.enable;

	// tap positions: second tap half a window further on
	assign d2   = phase_q + PH_W'(1 << (PH_W - 1));
	assign pos1 = {wp_q, {FRAC_W{1'b0}}} - POS_W'(phase_q);
	assign pos2 = {wp_q, {FRAC_W{1'b0}}} - POS_W'(d2);

	// triangle crossfade weight of the first tap
	assign dist_s   = $signed({1'b0, phase_q, 1'b0}) - $signed((PH_W+2)'(1 << PH_W));
	assign dist_mag = dist_s[PH_W+1] ? (PH_W+1)'(-dist_s) : dist_s[PH_W:0];
	assign w1       = 17'h10000 - 17'(dist_mag >> DL_LOG2);

	// phase drift by one minus pitch, wrapped into the window
	assign ph_sum = $signed({2'b00, phase_q}) + (PH_W+2)'(65536)
		- $signed((PH_W+2)'(cfg.pitch));
	always_comb begin
		if (ph_sum >= $signed((PH_W+2)'(1 << PH_W))) begin
			ph_next = ph_sum[PH_W-1:0];
		end else if (ph_sum < 0) begin
			ph_next = ph_sum[PH_W-1:0];
		end else begin
			ph_next = ph_sum[PH_W-1:0];
		end
	end

	// item parameters latched at start
	always_ff @(posedge clk) begin
		if (start) begin
			pass_q <= (cfg.pitch == PITCH_UNITY);
			pos1_q <= pos1;
			pos2_q <= pos2;
			w1_q   <= w1;
			dw_q   <= (cfg.dry_wet > DW_FULL) ? DW_FULL : cfg.dry_wet;
		end
	end

	// state, sweep counter, write position and phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			wp_q    <= '0;
			phase_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (done) begin
				wp_q <= wp_q + 1'b1;
				if (!pass_q) begin
					phase_q <= ph_next;
				end
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: if (&clr_q) state_d = ST_IDLE;
			ST_IDLE:  if (start) state_d = ST_WR;
			ST_WR:    state_d = pass_q ? ST_C6 : ST_RD0;
			ST_RD0:   state_d = ST_RD1;
			ST_RD1:   state_d = ST_RD2;
			ST_RD2:   state_d = ST_RD3;
			ST_RD3:   state_d = ST_C1;
			ST_C1:    state_d = ST_C2;
			ST_C2:    state_d = ST_C3;
			ST_C3:    state_d = ST_C4;
			ST_C4:    state_d = ST_C5;
			ST_C5:    state_d = ST_C6;
			ST_C6:    if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_CLEAR;
		endcase
	end

	// outputs to the lanes
	always_comb begin
		in_ready    = (state_q == ST_IDLE) && out_free;
		done        = (state_q == ST_C6) && out_free;
		ctl         = '0;
		ctl.load    = in_ready && in_valid;
		ctl.pass    = pass_q;
		ctl.f1      = pos1_q[FRAC_W-1:0];
		ctl.f2      = pos2_q[FRAC_W-1:0];
		ctl.w1      = w1_q;
		ctl.dw      = dw_q;
		ctl.addr    = wp_q;
		case (state_q)
			ST_CLEAR: begin
				ctl.we      = 1'b1;
				ctl.wr_zero = 1'b1;
				ctl.addr    = clr_q;
			end
			ST_WR: begin
				ctl.we = 1'b1;
			end
			ST_RD0: ctl.addr = pos1_q[POS_W-1:FRAC_W];
			ST_RD1: begin
				ctl.addr   = pos1_q[POS_W-1:FRAC_W] + 1'b1;
				ctl.cap_a0 = 1'b1;
			end
			ST_RD2: begin
				ctl.addr   = pos2_q[POS_W-1:FRAC_W];
				ctl.cap_a1 = 1'b1;
			end
			ST_RD3: begin
				ctl.addr   = pos2_q[POS_W-1:FRAC_W] + 1'b1;
				ctl.cap_b0 = 1'b1;
			end
			ST_C1:   ctl.do_c1 = 1'b1;
			ST_C2:   ctl.do_c2 = 1'b1;
			ST_C3:   ctl.do_c3 = 1'b1;
			ST_C4:   ctl.do_c4 = 1'b1;
			ST_C5:   ctl.do_c5 = 1'b1;
			default: ctl.we = 1'b0;
		endcase
	end

endmodule

`default_nettype wire

@@ hw/rtl/delay_line_pitch_shifter_top.sv @@
`default_nettype none

// Two-tap crossfading delay-line pitch shifter for a stereo audio frame.
// Input frames come in on the s_ stream (left sample in the low half of
// s_tdata), results leave on the m_ stream in the same layout. Settings are
// written through the APB port: enable, channels, pitch_factor, dry_wet at
// byte addresses 0, 4, 8, 12; the user must change them only while no frame
// is in work, which the block does not enforce. Each channel has its own
// lane with a 4096-entry single-port delay store. An enabled frame reaches
// its result register through one store write, four tap reads and six
// arithmetic steps, set by the one store port and the multiply chain. No new
// frame is accepted while one is in work. At unity pitch the frame takes the
// store write only; with the block disabled the input is written into the
// result register at the accepting edge and offered on m_ in the next cycle.
// After reset both stores are cleared by a sweep over all 4096 entries,
// during which s_tready stays low; configuration writes are taken at any time.
// A stalled receiver holds the result register, and s_tready stays low until
// that result is taken, so at most one frame is in the block at a time.
module delay_line_pitch_shifter_top
	import dlps_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// stream in
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // [15:0] left_sample, [31:16] right_sample
	// stream out
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [31:0] m_tdata,   // [15:0] left_out, [31:16] right_out
	// configuration
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);

	dlps_cfg_t          cfg_q;
	dlps_ctl_t          ctl;
	logic               out_valid_q;
	logic        [31:0] out_data_q;
	logic               out_free;
	logic               done;
	logic               bypass;
	logic signed [15:0] y_left, y_right;

	assign pready = 1'b1;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable   <= 1'b0;
			cfg_q.channels <= 2'd2;
			cfg_q.pitch    <= PITCH_UNITY;
			cfg_q.dry_wet  <= DW_FULL;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[3:2])
				REG_ENABLE:   cfg_q.enable   <= pwdata[0];
				REG_CHANNELS: cfg_q.channels <= pwdata[1:0];
				REG_PITCH:    cfg_q.pitch    <= pwdata[17:0];
				REG_DRY_WET:  cfg_q.dry_wet  <= pwdata[15:0];
				default:      cfg_q.enable   <= cfg_q.enable;
			endcase
		end
	end

	// register reads
	always_comb begin
		case (paddr[3:2])
			REG_ENABLE:   prdata = {31'h0, cfg_q.enable};
			REG_CHANNELS: prdata = {30'h0, cfg_q.channels};
			REG_PITCH:    prdata = {14'h0, cfg_q.pitch};
			REG_DRY_WET:  prdata = {16'h0, cfg_q.dry_wet};
			default:      prdata = 32'h0;
		endcase
	end

	assign out_free = !out_valid_q || m_tready;
	assign bypass   = s_tvalid && s_tready && !cfg_q.enable;

	dlps_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.in_valid(s_tvalid),
		.out_free(out_free),
		.in_ready(s_tready),
		.done    (done),
		.ctl     (ctl)
	);

	dlps_lane u_lane_left (
		.clk   (clk),
		.ctl   (ctl),
		.active(1'b1),
		.x_in  ($signed(s_tdata[15:0])),
		.y     (y_left)
	);

	dlps_lane u_lane_right (
		.clk   (clk),
		.ctl   (ctl),
		.active(cfg_q.channels[1]),
		.x_in  ($signed(s_tdata[31:16])),
		.y     (y_right)
	);

	// merge the lanes into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done || bypass) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (bypass) begin
			out_data_q <= s_tdata;
		end else if (done) begin
			out_data_q <= {y_right, y_left};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

`default_nettype wire
